@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define CALU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define CALU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/calu_pkg.sv @@
// ----------------------------------------------------------------------------
// calu_pkg
// Opcodes, word types and flag helpers for the 8/16-bit ALU with flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package calu_pkg;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_ADC  = 5'd1,
        OP_SUB  = 5'd2,
        OP_SBC  = 5'd3,
        OP_CP   = 5'd4,
        OP_AND  = 5'd5,
        OP_OR   = 5'd6,
        OP_XOR  = 5'd7,
        OP_INC  = 5'd8,
        OP_DEC  = 5'd9,
        OP_RLC  = 5'd10,
        OP_RRC  = 5'd11,
        OP_RL   = 5'd12,
        OP_RR   = 5'd13,
        OP_SLA  = 5'd14,
        OP_SRA  = 5'd15,
        OP_SLL  = 5'd16,
        OP_SRL  = 5'd17,
        OP_BIT  = 5'd18,
        OP_SET  = 5'd19,
        OP_RES  = 5'd20,
        OP_ADDW = 5'd21,
        OP_ADCW = 5'd22,
        OP_SBCW = 5'd23
    } calu_op_t;

    localparam int unsigned FLAG_S = 7;
    localparam int unsigned FLAG_Z = 6;
    localparam int unsigned FLAG_H = 4;
    localparam int unsigned FLAG_V = 2;
    localparam int unsigned FLAG_N = 1;
    localparam int unsigned FLAG_C = 0;

    typedef struct packed {
        logic [4:0]  opcode;
        logic [7:0]  acc_in;
        logic [7:0]  operand_byte;
        logic [7:0]  flags_in;
        logic [15:0] word_left;
        logic [15:0] word_right;
        logic [2:0]  bit_index;
    } calu_in_t;

    typedef struct packed {
        logic [7:0]  byte_result;
        logic [15:0] word_result;
        logic [7:0]  flags_out;
    } calu_out_t;

    function automatic logic [7:0] flags_pack(
        input logic s,
        input logic z,
        input logic h,
        input logic v,
        input logic n,
        input logic c
    );
        logic [7:0] f;
        f = 8'h00;
        f[FLAG_S] = s;
        f[FLAG_Z] = z;
        f[FLAG_H] = h;
        f[FLAG_V] = v;
        f[FLAG_N] = n;
        f[FLAG_C] = c;
        return f;
    endfunction

    // S, Z and even parity on P/V, N cleared, with H and C supplied
    function automatic logic [7:0] flags_logic(
        input logic [7:0] v,
        input logic       h,
        input logic       c
    );
        return flags_pack(v[7], v == 8'h00, h, ~(^v), 1'b0, c);
    endfunction

endpackage

`default_nettype wire

@@ design/cpu_alu_with_flags_top.sv @@
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_top
// Z80-style 8/16-bit ALU with flag generation, one operation per word.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word on cmd is taken at each rising edge with start
//   high and busy low. busy is held low, so a new word may be issued every
//   cycle.
//   Result channel: done is high for exactly one cycle while result carries
//   byte_result, word_result and flags_out for that word. The receiver must
//   take it in that cycle; it cannot stall the unit.
//   Path: an accepted word is held in the input register, then in the result
//   register, which is loaded together with done.
//   Throughput: one word per cycle; the path between the two registers is
//   one 17-bit add or subtract plus flag logic and a result select.
//   Results come out in command order.
//   Reset (rst_n low, asynchronous) drops any word in flight; done is low
//   until the first word after reset has passed both registers.
//   Unused opcodes return acc_in, word_left and flags_in unchanged.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpu_alu_with_flags_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire calu_pkg::calu_in_t cmd,
    output logic                    done,
    output calu_pkg::calu_out_t     result
);

    logic                valid_reg;
    calu_pkg::calu_in_t  cmd_reg;
    logic                done_reg;
    calu_pkg::calu_out_t result_reg;
    calu_pkg::calu_out_t result_next;

    logic        accept;
    logic        cin;
    logic        cy8;
    logic        cyw;
    logic [7:0]  a;
    logic [7:0]  r;
    logic [7:0]  f;
    logic [15:0] wl;
    logic [15:0] wr;
    logic [7:0]  mask;
    logic [8:0]  sum9;
    logic [8:0]  dif9;
    logic [16:0] sum17;
    logic [16:0] dif17;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic [7:0]  sh8;
    logic        sh_c;
    logic [7:0]  bit8;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
            done_reg  <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        if (valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign a    = cmd_reg.acc_in;
    assign r    = cmd_reg.operand_byte;
    assign f    = cmd_reg.flags_in;
    assign wl   = cmd_reg.word_left;
    assign wr   = cmd_reg.word_right;
    assign cin  = f[calu_pkg::FLAG_C];
    assign mask = 8'b1 << cmd_reg.bit_index;
    assign bit8 = r & mask;

    assign cy8 = ((cmd_reg.opcode == calu_pkg::OP_ADC) || (cmd_reg.opcode == calu_pkg::OP_SBC))
                 ? cin : 1'b0;
    assign cyw = (cmd_reg.opcode == calu_pkg::OP_ADDW) ? 1'b0 : cin;

    assign sum9  = {1'b0, a} + {1'b0, r} + {8'h00, cy8};
    assign dif9  = {1'b0, a} - {1'b0, r} - {8'h00, cy8};
    assign sum17 = {1'b0, wl} + {1'b0, wr} + {16'h0000, cyw};
    assign dif17 = {1'b0, wl} - {1'b0, wr} - {16'h0000, cin};
    assign inc8  = r + 8'h01;
    assign dec8  = r - 8'h01;

    always_comb
    begin
        sh8  = r;
        sh_c = 1'b0;
        case (cmd_reg.opcode)
            calu_pkg::OP_RLC: begin sh8 = {r[6:0], r[7]};  sh_c = r[7]; end
            calu_pkg::OP_RRC: begin sh8 = {r[0], r[7:1]};  sh_c = r[0]; end
            calu_pkg::OP_RL:  begin sh8 = {r[6:0], cin};   sh_c = r[7]; end
            calu_pkg::OP_RR:  begin sh8 = {cin, r[7:1]};   sh_c = r[0]; end
            calu_pkg::OP_SLA: begin sh8 = {r[6:0], 1'b0};  sh_c = r[7]; end
            calu_pkg::OP_SRA: begin sh8 = {r[7], r[7:1]};  sh_c = r[0]; end
            calu_pkg::OP_SLL: begin sh8 = {r[6:0], 1'b1};  sh_c = r[7]; end
            calu_pkg::OP_SRL: begin sh8 = {1'b0, r[7:1]};  sh_c = r[0]; end
            default:          begin sh8 = r;               sh_c = 1'b0; end
        endcase
    end

    always_comb
    begin
        result_next.byte_result = a;
        result_next.word_result = wl;
        result_next.flags_out   = f;
        case (cmd_reg.opcode)
            calu_pkg::OP_ADD, calu_pkg::OP_ADC:
            begin
                result_next.byte_result = sum9[7:0];
                result_next.flags_out = calu_pkg::flags_pack(
                    sum9[7], sum9[7:0] == 8'h00, a[4] ^ r[4] ^ sum9[4],
                    ~(a[7] ^ r[7]) & (r[7] ^ sum9[7]), 1'b0, sum9[8]);
            end
            calu_pkg::OP_SUB, calu_pkg::OP_SBC, calu_pkg::OP_CP:
            begin
                if (cmd_reg.opcode != calu_pkg::OP_CP)
                begin
                    result_next.byte_result = dif9[7:0];
                end
                result_next.flags_out = calu_pkg::flags_pack(
                    dif9[7], dif9[7:0] == 8'h00, a[4] ^ r[4] ^ dif9[4],
                    (a[7] ^ r[7]) & (a[7] ^ dif9[7]), 1'b1, dif9[8]);
            end
            calu_pkg::OP_AND:
            begin
                result_next.byte_result = a & r;
                result_next.flags_out   = calu_pkg::flags_logic(a & r, 1'b1, 1'b0);
            end
            calu_pkg::OP_OR:
            begin
                result_next.byte_result = a | r;
                result_next.flags_out   = calu_pkg::flags_logic(a | r, 1'b0, 1'b0);
            end
            calu_pkg::OP_XOR:
            begin
                result_next.byte_result = a ^ r;
                result_next.flags_out   = calu_pkg::flags_logic(a ^ r, 1'b0, 1'b0);
            end
            calu_pkg::OP_INC:
            begin
                result_next.byte_result = inc8;
                result_next.flags_out = calu_pkg::flags_pack(
                    inc8[7], inc8 == 8'h00, inc8[3:0] == 4'h0,
                    inc8 == 8'h80, 1'b0, cin);
            end
            calu_pkg::OP_DEC:
            begin
                result_next.byte_result = dec8;
                result_next.flags_out = calu_pkg::flags_pack(
                    dec8[7], dec8 == 8'h00, dec8[3:0] == 4'hF,
                    dec8 == 8'h7F, 1'b1, cin);
            end
            calu_pkg::OP_RLC, calu_pkg::OP_RRC, calu_pkg::OP_RL, calu_pkg::OP_RR,
            calu_pkg::OP_SLA, calu_pkg::OP_SRA, calu_pkg::OP_SLL, calu_pkg::OP_SRL:
            begin
                result_next.byte_result = sh8;
                result_next.flags_out   = calu_pkg::flags_logic(sh8, 1'b0, sh_c);
            end
            calu_pkg::OP_BIT:
            begin
                result_next.flags_out = calu_pkg::flags_logic(bit8, 1'b1, cin);
            end
            calu_pkg::OP_SET:
            begin
                result_next.byte_result = r | mask;
            end
            calu_pkg::OP_RES:
            begin
                result_next.byte_result = r & ~mask;
            end
            calu_pkg::OP_ADDW:
            begin
                result_next.word_result = sum17[15:0];
                result_next.flags_out   = f;
                result_next.flags_out[calu_pkg::FLAG_H] = wl[12] ^ wr[12] ^ sum17[12];
                result_next.flags_out[calu_pkg::FLAG_N] = 1'b0;
                result_next.flags_out[calu_pkg::FLAG_C] = sum17[16];
            end
            calu_pkg::OP_ADCW:
            begin
                result_next.word_result = sum17[15:0];
                result_next.flags_out = calu_pkg::flags_pack(
                    sum17[15], sum17[15:0] == 16'h0000, wl[12] ^ wr[12] ^ sum17[12],
                    ~(wl[15] ^ wr[15]) & (wr[15] ^ sum17[15]), 1'b0, sum17[16]);
            end
            calu_pkg::OP_SBCW:
            begin
                result_next.word_result = dif17[15:0];
                result_next.flags_out = calu_pkg::flags_pack(
                    dif17[15], dif17[15:0] == 16'h0000, wl[12] ^ wr[12] ^ dif17[12],
                    (wl[15] ^ wr[15]) & (wl[15] ^ dif17[15]), 1'b1, dif17[16]);
            end
            default:
            begin
                result_next.byte_result = a;
                result_next.word_result = wl;
                result_next.flags_out   = f;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

`include "assert_macros.svh"

    `CALU_ASSERT_NEXT(a_accept_loads, accept, valid_reg,
        "accepted word did not reach the input register")
    `CALU_ASSERT_NEXT(a_stage_to_done, valid_reg, done,
        "registered word did not produce a result strobe")
    `CALU_ASSERT_NOW(a_done_has_source, done, $past(accept, 2),
        "result strobe without a matching command")
    `CALU_ASSERT_NEXT(a_bitop_keeps_flags,
        valid_reg && ((cmd_reg.opcode == calu_pkg::OP_SET) ||
                      (cmd_reg.opcode == calu_pkg::OP_RES)),
        result.flags_out == $past(cmd_reg.flags_in),
        "set/res changed the flags")
    `CALU_ASSERT_NEXT(a_cp_keeps_acc,
        valid_reg && (cmd_reg.opcode == calu_pkg::OP_CP),
        result.byte_result == $past(cmd_reg.acc_in),
        "compare changed the accumulator")

endmodule

`default_nettype wire
